// ===== rtl/retransmit_timer_table_unit_macros.svh =====
// Assertion macros for the retransmit timer table.
// Depends on: a clk and arst_n in the scope of the user.
`ifndef RETRANSMIT_TIMER_TABLE_UNIT_MACROS_SVH
`define RETRANSMIT_TIMER_TABLE_UNIT_MACROS_SVH

// condition must hold at every edge out of reset
`define RTTU_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RTTU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rttu_pkg.sv =====
// Package of the retransmit timer table: entry and result types, codes, defaults.
// Depends on: nothing.
package rttu_pkg;

	localparam int ENTRIES_DEF   = 16;
	localparam int RES_SHIFT_DEF = 0;
	localparam int MAX_RESULTS   = 16;
	localparam int NW            = $clog2(MAX_RESULTS + 1);
	localparam logic [15:0] UNLIMITED = 16'hFFFF;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_CANCELLED = 3'd2;
	localparam logic [2:0] ST_NOTFOUND  = 3'd3;
	localparam logic [2:0] ST_FIRED     = 3'd4;
	localparam logic [2:0] ST_EXPIRED   = 3'd5;

	typedef struct packed {
		logic        kind;
		logic [15:0] id;
		logic [31:0] due;
		logic [31:0] period;
		logic [15:0] limit;
		logic [15:0] retries;
	} entry_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] id;
		logic        kind;
		logic [15:0] retries;
	} res_t;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_ADEC   = 7'b0000100,
		S_CDEC   = 7'b0001000,
		S_TDEC   = 7'b0010000,
		S_PUSH   = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	// next candidate id, zero skipped
	function automatic logic [15:0] next_id(input logic [15:0] x);
		logic [15:0] y;
		y = x + 16'd1;
		if (y == 16'd0)
			y = 16'd1;
		return y;
	endfunction

endpackage

// ===== rtl/rttu_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// Depends on: nothing.
module rttu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/retransmit_timer_table_unit.sv =====
// Top level of the retransmit timer table: control sequencer around one entry RAM.
// Depends on: rttu_pkg, rttu_ram, retransmit_timer_table_unit_macros.svh.
//
// One input transfer at a time. Entries live in a RAM of ENTRIES words that
// is read one slot per cycle; valid bits sit in flops. Each add, cancel and
// tick sweeps the whole RAM:
//   cancel: one sweep.
//   add:    k+1 sweeps, k = ids skipped because in use
//           (k <= ENTRIES-1); table full answers without a sweep.
//   tick:   one sweep per result plus a final one unless the cap is reached,
//           at most 16 results per tick.
// A stalled master side holds the sequencer back in its push and finish
// states. A result waiting on the master side does not block the next input
// transfer; the final result of an operation carries tlast, a tick with
// nothing due gives no transfer.
`include "retransmit_timer_table_unit_macros.svh"
module retransmit_timer_table_unit
	import rttu_pkg::*;
#(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int RES_SHIFT = RES_SHIFT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // first_delay[31:0], period[63:32], max_count[79:64], event_id[95:80]
	input  logic [2:0]  s_tuser,  // op[1:0], kind[2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // result_id[15:0], retry_count[31:16]
	output logic [3:0]  m_tuser,  // status[2:0], result_kind[3]
	output logic        m_tlast
);
	localparam int IW = $clog2(ENTRIES);
	localparam int EW = $bits(entry_t);

	state_t             state_q;
	logic [1:0]         op_q;
	logic               kind_in_q;
	logic [31:0]        fd_q, per_q;
	logic [15:0]        max_q, evid_q;
	logic [31:0]        now_q;
	logic [15:0]        last_id_q, cand_q;
	logic [ENTRIES-1:0] valid_q, done_q;
	logic [IW-1:0]      scan_q, free_slot_q, sel_slot_q, rd_slot_s1;
	logic               issuing_q, rd_vld_s1, sel_vld_q;
	entry_t             sel_q;
	res_t               res_q, pend_q, out_q;
	logic               pend_vld_q, out_last_q, m_tvalid_q;
	logic [NW-1:0]      n_q;

	// RAM ports
	logic          wr_en;
	logic [IW-1:0] waddr;
	entry_t        wdata, rdata;
	logic [EW-1:0] rdata_raw;

	rttu_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(scan_q),
		.rdata(rdata_raw)
	);
	assign rdata = entry_t'(rdata_raw);

	// first free slot, lowest index
	logic [IW-1:0] free_slot;
	logic          full;
	always_comb begin
		free_slot = '0;
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (!valid_q[i])
				free_slot = IW'(i);
		full = &valid_q;
	end

	// tick decision on the selected entry
	logic        exhausted, due_ok;
	logic [15:0] ret_inc;
	assign exhausted = (sel_q.limit != UNLIMITED) && (sel_q.retries >= sel_q.limit);
	assign due_ok    = (sel_q.due == 32'd0) || ((sel_q.due >> RES_SHIFT) <= (now_q >> RES_SHIFT));
	assign ret_inc   = (sel_q.retries == 16'hFFFF) ? sel_q.retries : sel_q.retries + 16'd1;

	always_comb begin
		wr_en = 1'b0;
		waddr = sel_slot_q;
		wdata = sel_q;
		if (state_q == S_ADEC && !sel_vld_q) begin
			wr_en = 1'b1;
			waddr = free_slot_q;
			wdata = '{kind: kind_in_q, id: cand_q, due: now_q + fd_q, period: per_q,
				limit: max_q, retries: 16'd0};
		end else if (state_q == S_TDEC && sel_vld_q && !exhausted && due_ok) begin
			wr_en         = 1'b1;
			wdata.retries = ret_inc;
			wdata.due     = now_q + sel_q.period;
		end
	end

	// sweep comparison for the tick: earlier due, then lower kind
	logic better;
	assign better = !sel_vld_q || (rdata.due < sel_q.due) ||
		(rdata.due == sel_q.due && rdata.kind < sel_q.kind);

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	// pending result moves into the output register this cycle
	logic load_out;
	assign load_out = pend_vld_q && out_free && (state_q == S_PUSH || state_q == S_FINISH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_ADD;
			kind_in_q   <= 1'b0;
			fd_q        <= '0;
			per_q       <= '0;
			max_q       <= '0;
			evid_q      <= '0;
			now_q       <= '0;
			last_id_q   <= 16'd1;
			cand_q      <= '0;
			valid_q     <= '0;
			done_q      <= '0;
			scan_q      <= '0;
			free_slot_q <= '0;
			sel_slot_q  <= '0;
			rd_slot_s1  <= '0;
			issuing_q   <= 1'b0;
			rd_vld_s1   <= 1'b0;
			sel_vld_q   <= 1'b0;
			sel_q       <= '0;
			res_q       <= '0;
			pend_q      <= '0;
			out_q       <= '0;
			pend_vld_q  <= 1'b0;
			out_last_q  <= 1'b0;
			m_tvalid_q  <= 1'b0;
			n_q         <= '0;
		end else begin
			if (m_tvalid_q && m_tready && !load_out)
				m_tvalid_q <= 1'b0;
			rd_vld_s1 <= (state_q == S_SCAN) && issuing_q;

			case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					op_q      <= s_tuser[1:0];
					kind_in_q <= s_tuser[2];
					fd_q      <= s_tdata[31:0];
					per_q     <= s_tdata[63:32];
					max_q     <= s_tdata[79:64];
					evid_q    <= s_tdata[95:80];
					scan_q    <= '0;
					sel_vld_q <= 1'b0;
					case (s_tuser[1:0])
					OP_ADD: begin
						if (full) begin
							res_q     <= '{status: ST_FULL, id: 16'd0, kind: s_tuser[2],
								retries: 16'd0};
							state_q   <= S_PUSH;
						end else begin
							free_slot_q <= free_slot;
							cand_q      <= next_id(last_id_q);
							issuing_q   <= 1'b1;
							state_q     <= S_SCAN;
						end
					end
					OP_CANCEL: begin
						issuing_q <= 1'b1;
						state_q   <= S_SCAN;
					end
					OP_TICK: begin
						now_q     <= now_q + 32'd1;
						done_q    <= '0;
						n_q       <= '0;
						issuing_q <= 1'b1;
						state_q   <= S_SCAN;
					end
					default: state_q <= S_IDLE;  // unknown op: no effect
					endcase
				end
			end
			S_SCAN: begin
				if (issuing_q) begin
					rd_slot_s1 <= scan_q;
					if (scan_q == IW'(ENTRIES - 1))
						issuing_q <= 1'b0;
					else
						scan_q <= scan_q + 1'b1;
				end
				if (rd_vld_s1 && valid_q[rd_slot_s1]) begin
					case (op_q)
					OP_ADD:
						if (rdata.id == cand_q)
							sel_vld_q <= 1'b1;
					OP_CANCEL:
						if (rdata.id == evid_q) begin
							sel_vld_q  <= 1'b1;
							sel_slot_q <= rd_slot_s1;
							sel_q      <= rdata;
						end
					default:
						if (!done_q[rd_slot_s1] && better) begin
							sel_vld_q  <= 1'b1;
							sel_slot_q <= rd_slot_s1;
							sel_q      <= rdata;
						end
					endcase
				end
				if (rd_vld_s1 && rd_slot_s1 == IW'(ENTRIES - 1)) begin
					case (op_q)
					OP_ADD:    state_q <= S_ADEC;
					OP_CANCEL: state_q <= S_CDEC;
					default:   state_q <= S_TDEC;
					endcase
				end
			end
			S_ADEC: begin
				if (sel_vld_q) begin
					// candidate in use, try the next one
					cand_q    <= next_id(cand_q);
					scan_q    <= '0;
					issuing_q <= 1'b1;
					sel_vld_q <= 1'b0;
					state_q   <= S_SCAN;
				end else begin
					valid_q[free_slot_q] <= 1'b1;
					last_id_q <= cand_q;
					res_q     <= '{status: ST_ADDED, id: cand_q, kind: kind_in_q, retries: 16'd0};
					state_q   <= S_PUSH;
				end
			end
			S_CDEC: begin
				if (sel_vld_q) begin
					valid_q[sel_slot_q] <= 1'b0;
					res_q <= '{status: ST_CANCELLED, id: evid_q, kind: sel_q.kind,
						retries: sel_q.retries};
				end else begin
					res_q <= '{status: ST_NOTFOUND, id: evid_q, kind: 1'b0, retries: 16'd0};
				end
				state_q <= S_PUSH;
			end
			S_TDEC: begin
				if (!sel_vld_q) begin
					state_q <= S_FINISH;
				end else begin
					done_q[sel_slot_q] <= 1'b1;
					if (exhausted) begin
						valid_q[sel_slot_q] <= 1'b0;
						res_q   <= '{status: ST_EXPIRED, id: sel_q.id, kind: sel_q.kind,
							retries: sel_q.retries};
						n_q     <= n_q + 1'b1;
						state_q <= S_PUSH;
					end else if (due_ok) begin
						res_q   <= '{status: ST_FIRED, id: sel_q.id, kind: sel_q.kind,
							retries: ret_inc};
						n_q     <= n_q + 1'b1;
						state_q <= S_PUSH;
					end else begin
						state_q <= S_FINISH;
					end
				end
			end
			S_PUSH: begin
				// hold one result back so the final one can carry tlast
				if (!pend_vld_q || out_free) begin
					if (pend_vld_q) begin
						out_q      <= pend_q;
						out_last_q <= 1'b0;
						m_tvalid_q <= 1'b1;
					end
					pend_q     <= res_q;
					pend_vld_q <= 1'b1;
					if (op_q == OP_TICK && n_q < NW'(MAX_RESULTS)) begin
						scan_q    <= '0;
						issuing_q <= 1'b1;
						sel_vld_q <= 1'b0;
						state_q   <= S_SCAN;
					end else begin
						state_q <= S_FINISH;
					end
				end
			end
			S_FINISH: begin
				if (!pend_vld_q) begin
					state_q <= S_IDLE;
				end else if (out_free) begin
					out_q      <= pend_q;
					out_last_q <= 1'b1;
					m_tvalid_q <= 1'b1;
					pend_vld_q <= 1'b0;
					state_q    <= S_IDLE;
				end
			end
			default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_q.kind, out_q.status};
	assign m_tdata  = {out_q.retries, out_q.id};

	`RTTU_ASSERT_ALWAYS(a_no_write_in_sweep, !(wr_en && state_q == S_SCAN), "RAM write during sweep")
	`RTTU_ASSERT_ALWAYS(a_result_cap, n_q <= NW'(MAX_RESULTS), "tick result count above cap")
	`RTTU_ASSERT_NEXT(a_final_sent, state_q == S_FINISH && pend_vld_q && out_free, m_tvalid && m_tlast && !pend_vld_q, "final result not presented with tlast")
endmodule

// ===== dv/tb_retransmit_timer_table_unit.sv =====
// Testbench of retransmit_timer_table_unit: directed table then random adds, cancels and ticks.
// Depends on: rttu_pkg and the RTL of the timer table; results checked against a local predictor.
module tb_retransmit_timer_table_unit;
	import rttu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 16;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;   // first_delay[31:0], period[63:32], max_count[79:64], event_id[95:80]
	logic [2:0]  s_tuser;   // op[1:0], kind[2]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // result_id[15:0], retry_count[31:16]
	logic [3:0]  m_tuser;   // status[2:0], result_kind[3]
	logic        m_tlast;

	retransmit_timer_table_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// one timer request as the sender sees it
	typedef struct {
		logic [1:0]  op;
		logic        kind;
		logic [31:0] first_delay;
		logic [31:0] period;
		logic [15:0] max_count;
		logic [15:0] event_id;
	} request_t;

	// one table event as it leaves the block
	typedef struct {
		logic [2:0]  status;
		logic [15:0] id;
		logic        kind;
		logic [15:0] retries;
		logic        last;
	} table_event_t;

	// shadow of the table
	logic        tbl_valid   [NSLOT];
	logic        tbl_kind    [NSLOT];
	logic [15:0] tbl_id      [NSLOT];
	logic [31:0] tbl_due     [NSLOT];
	logic [31:0] tbl_period  [NSLOT];
	logic [15:0] tbl_limit   [NSLOT];
	logic [15:0] tbl_retries [NSLOT];
	logic [31:0] clock_now;
	logic [15:0] newest_id;

	table_event_t pending_events[$];
	int errors = 0;
	bit random_idle;

	always #5 clk = ~clk;

	function automatic table_event_t mk_event(logic [2:0] st, logic [15:0] id, logic kd,
			logic [15:0] rc);
		table_event_t e;
		e.status = st;
		e.id = id;
		e.kind = kd;
		e.retries = rc;
		e.last = 1'b0;
		return e;
	endfunction

	// adds one event at the tail of a queue
	function automatic void append_event(ref table_event_t q[$], input table_event_t e);
		q = {q, e};
	endfunction

	function automatic bit id_taken(logic [15:0] id);
		for (int i = 0; i < NSLOT; i++)
			if (tbl_valid[i] && tbl_id[i] == id)
				return 1;
		return 0;
	endfunction

	// advances the shadow table by one request, returns the events it causes
	function automatic void predict_events(request_t r, ref table_event_t evs[$]);
		int slot;
		int best;
		bit handled[NSLOT];
		logic [15:0] nid;
		evs = {};
		case (r.op)
			OP_ADD: begin
				slot = -1;
				for (int i = NSLOT - 1; i >= 0; i--)
					if (!tbl_valid[i])
						slot = i;
				if (slot < 0) begin
					append_event(evs, mk_event(ST_FULL, 16'd0, r.kind, 16'd0));
				end else begin
					nid = newest_id + 16'd1;
					while (nid == 16'd0 || id_taken(nid))
						nid = nid + 16'd1;
					newest_id = nid;
					tbl_valid[slot] = 1'b1;
					tbl_kind[slot] = r.kind;
					tbl_id[slot] = nid;
					tbl_due[slot] = clock_now + r.first_delay;
					tbl_period[slot] = r.period;
					tbl_limit[slot] = r.max_count;
					tbl_retries[slot] = 16'd0;
					append_event(evs, mk_event(ST_ADDED, nid, r.kind, 16'd0));
				end
			end
			OP_CANCEL: begin
				slot = -1;
				for (int i = NSLOT - 1; i >= 0; i--)
					if (tbl_valid[i] && tbl_id[i] == r.event_id)
						slot = i;
				if (slot < 0) begin
					append_event(evs, mk_event(ST_NOTFOUND, r.event_id, 1'b0, 16'd0));
				end else begin
					tbl_valid[slot] = 1'b0;
					append_event(evs, mk_event(ST_CANCELLED, r.event_id, tbl_kind[slot],
						tbl_retries[slot]));
				end
			end
			OP_TICK: begin
				foreach (handled[i])
					handled[i] = 0;
				clock_now = clock_now + 32'd1;
				while (evs.size() < MAX_RESULTS) begin
					best = -1;
					for (int i = 0; i < NSLOT; i++) begin
						if (!tbl_valid[i] || handled[i])
							continue;
						if (best < 0 || tbl_due[i] < tbl_due[best] ||
								(tbl_due[i] == tbl_due[best] && tbl_kind[i] < tbl_kind[best]))
							best = i;
					end
					if (best < 0)
						break;
					handled[best] = 1;
					if (tbl_limit[best] != UNLIMITED && tbl_retries[best] >= tbl_limit[best]) begin
						tbl_valid[best] = 1'b0;
						append_event(evs, mk_event(ST_EXPIRED, tbl_id[best], tbl_kind[best],
							tbl_retries[best]));
					end else if (tbl_due[best] == 32'd0 || tbl_due[best] <= clock_now) begin
						if (tbl_retries[best] != 16'hFFFF)
							tbl_retries[best] = tbl_retries[best] + 16'd1;
						tbl_due[best] = clock_now + tbl_period[best];
						append_event(evs, mk_event(ST_FIRED, tbl_id[best], tbl_kind[best],
							tbl_retries[best]));
					end else begin
						break;
					end
				end
			end
			default: ;
		endcase
		if (evs.size() > 0)
			evs[evs.size() - 1].last = 1'b1;
	endfunction

	function automatic request_t mk_req(logic [1:0] op, logic kd, logic [31:0] fd,
			logic [31:0] per, logic [15:0] mc, logic [15:0] eid);
		request_t r;
		r.op = op;
		r.kind = kd;
		r.first_delay = fd;
		r.period = per;
		r.max_count = mc;
		r.event_id = eid;
		return r;
	endfunction

	// sender idle burst, none late in the run
	task automatic sender_gap();
		int n;
		if (random_idle && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 19);
			repeat (n) @(posedge clk);
		end
	endtask

	// one transfer on the slave side; returns at the accepting edge with tvalid dropped
	task automatic drive_request(request_t r);
		@(posedge clk);
		sender_gap();
		s_tvalid <= 1'b1;
		s_tdata <= {r.event_id, r.max_count, r.period, r.first_delay};
		s_tuser <= {r.kind, r.op};
		do
			@(posedge clk);
		while (!s_tready);
		s_tvalid <= 1'b0;
	endtask

	// the predictor runs at acceptance
	task automatic send_request(request_t r);
		table_event_t evs[$];
		drive_request(r);
		predict_events(r, evs);
		pending_events = {pending_events, evs};
	endtask

	task automatic drain_events();
		while (pending_events.size() > 0)
			@(posedge clk);
		// a tick that fires nothing may still be sweeping
		repeat (400) @(posedge clk);
	endtask

	// receiver with random stall bursts
	initial begin
		int n;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (random_idle && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				n = $urandom_range(1, 19);
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// compare every accepted result with the oldest expectation
	always @(posedge clk) begin
		table_event_t exp_ev;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected result expected none actual st=%0d id=%0d",
					$time, m_tuser[2:0], m_tdata[15:0]);
				errors++;
			end else begin
				exp_ev = pending_events.pop_front();
				if (m_tuser[2:0] !== exp_ev.status) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_ev.status,
						m_tuser[2:0]);
					errors++;
				end
				if (m_tdata[15:0] !== exp_ev.id) begin
					$display("%0t: id expected %0d actual %0d", $time, exp_ev.id, m_tdata[15:0]);
					errors++;
				end
				if (m_tuser[3] !== exp_ev.kind) begin
					$display("%0t: kind expected %0d actual %0d", $time, exp_ev.kind, m_tuser[3]);
					errors++;
				end
				if (m_tdata[31:16] !== exp_ev.retries) begin
					$display("%0t: retries expected %0d actual %0d", $time, exp_ev.retries,
						m_tdata[31:16]);
					errors++;
				end
				if (m_tlast !== exp_ev.last) begin
					$display("%0t: last expected %0d actual %0d", $time, exp_ev.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// directed rows: request plus a hand-read expectation where obvious
	typedef struct {
		request_t req;
		bit       typed;
		logic [2:0]  st;
		logic [15:0] id;
	} row_t;

	function automatic row_t make_row(request_t q, bit t, logic [2:0] st, logic [15:0] id);
		row_t w;
		w.req = q;
		w.typed = t;
		w.st = st;
		w.id = id;
		return w;
	endfunction

	initial begin
		row_t rows[$];
		row_t rw;
		request_t r;
		table_event_t hand_evs[$];
		table_event_t typed_ev;
		logic [15:0] live_ids[$];
		int pick;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		random_idle = 1'b1;
		foreach (tbl_valid[i])
			tbl_valid[i] = 1'b0;
		clock_now = '0;
		newest_id = 16'd1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: first id is 2, empty tick gives nothing
		rows = {rows, make_row(mk_req(OP_TICK, 0, 0, 0, 0, 0), 1'b0, 3'd0, 16'd0)};
		rows = {rows, make_row(mk_req(OP_CANCEL, 0, 0, 0, 0, 16'hFFFF), 1'b1, ST_NOTFOUND,
			16'hFFFF)};
		rows = {rows, make_row(mk_req(OP_ADD, 1, 0, 0, 16'd3, 0), 1'b1, ST_ADDED, 16'd2)};
		rows = {rows, make_row(mk_req(OP_ADD, 0, 0, 0, 16'd3, 0), 1'b1, ST_ADDED, 16'd3)};
		rows = {rows, make_row(mk_req(OP_ADD, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, UNLIMITED, 0),
			1'b1, ST_ADDED, 16'd4)};
		rows = {rows, make_row(mk_req(OP_ADD, 1, 32'd2, 32'd1, 16'd0, 0), 1'b1, ST_ADDED,
			16'd5)};
		rows = {rows, make_row(mk_req(OP_TICK, 0, 0, 0, 0, 0), 1'b0, 3'd0, 16'd0)};
		rows = {rows, make_row(mk_req(OP_TICK, 0, 0, 0, 0, 0), 1'b0, 3'd0, 16'd0)};
		rows = {rows, make_row(mk_req(OP_TICK, 0, 0, 0, 0, 0), 1'b0, 3'd0, 16'd0)};
		rows = {rows, make_row(mk_req(OP_UNKNOWN, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
			16'hFFFF), 1'b0, 3'd0, 16'd0)};
		rows = {rows, make_row(mk_req(OP_CANCEL, 0, 0, 0, 0, 16'd4), 1'b0, 3'd0, 16'd0)};
		rows = {rows, make_row(mk_req(OP_CANCEL, 0, 0, 0, 0, 16'd0), 1'b1, ST_NOTFOUND,
			16'd0)};
		for (int i = 0; i < 17; i++)
			rows = {rows, make_row(mk_req(OP_ADD, i[0], 32'd1, 32'd0, UNLIMITED, 0), 1'b0,
				3'd0, 16'd0)};
		rows = {rows, make_row(mk_req(OP_TICK, 0, 0, 0, 0, 0), 1'b0, 3'd0, 16'd0)};
		rows = {rows, make_row(mk_req(OP_TICK, 0, 0, 0, 0, 0), 1'b0, 3'd0, 16'd0)};

		foreach (rows[k]) begin
			rw = rows[k];
			if (rw.typed) begin
				// status and id typed by hand, kind and retries from the shadow
				drive_request(rw.req);
				predict_events(rw.req, hand_evs);
				if (hand_evs.size() > 0)
					typed_ev = hand_evs[0];
				else
					typed_ev = mk_event(rw.st, rw.id, 1'b0, 16'd0);
				typed_ev.status = rw.st;
				typed_ev.id = rw.id;
				typed_ev.last = 1'b1;
				append_event(pending_events, typed_ev);
			end else begin
				send_request(rw.req);
			end
		end
		// clear the table so the random part starts roomy
		drain_events();
		for (int i = 0; i < 20; i++)
			send_request(mk_req(OP_TICK, 0, 0, 0, 16'd0, 0));
		drain_events();
		for (int i = 0; i < NSLOT; i++)
			if (tbl_valid[i])
				send_request(mk_req(OP_CANCEL, 0, 0, 0, 0, tbl_id[i]));

		// random part: mostly adds and ticks with small delays, some wide noise
		for (int n = 0; n < 72; n++) begin
			if (n == 36)
				drain_events();
			if (n == 60)
				random_idle = 1'b0;
			live_ids = {};
			for (int i = 0; i < NSLOT; i++)
				if (tbl_valid[i])
					live_ids = {live_ids, tbl_id[i]};
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				r = mk_req(OP_ADD, 1'($urandom_range(0, 1)), $urandom_range(0, 6),
					$urandom_range(0, 4), 16'($urandom_range(0, 5)), 16'($urandom));
				if ($urandom_range(0, 4) == 0)
					r.max_count = UNLIMITED;
				if ($urandom_range(0, 7) == 0) begin
					r.first_delay = $urandom;
					r.period = $urandom;
					r.max_count = 16'($urandom);
				end
			end else if (pick < 6) begin
				r = mk_req(OP_CANCEL, 1'($urandom_range(0, 1)), $urandom, $urandom,
					16'($urandom), 16'($urandom));
				if (live_ids.size() > 0 && $urandom_range(0, 2) != 0)
					r.event_id = live_ids[$urandom_range(0, live_ids.size() - 1)];
			end else begin
				r = mk_req(($urandom_range(0, 7) == 0) ? OP_UNKNOWN : OP_TICK,
					1'($urandom_range(0, 1)), $urandom, $urandom, 16'($urandom),
					16'($urandom));
			end
			send_request(r);
		end
		drain_events();
		if (errors == 0)
			$display("tb_retransmit_timer_table_unit: PASS");
		else
			$display("tb_retransmit_timer_table_unit: FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_retransmit_timer_table_unit: FAIL");
		$finish;
	end

endmodule
